### sv/mrc_pkg.sv
// shared types and constants for the clockwise matrix rotator
`default_nettype none

package mrc_pkg;

    // default largest side of the square matrix
    localparam int MAX_SIDE_DEF = 16;

    // width of the side length register
    localparam int SIDE_W = 5;

    // reset value of the side length register
    localparam logic [SIDE_W-1:0] SIDE_RESET = 5'd16;

    // element width
    localparam int DATA_W = 32;

    // result queue sizing (depth is a power of two)
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    // read request in flight from the front to the result queue
    typedef struct packed {
        logic valid;
        logic last;
    } mrc_tag_t;

    // one queued result
    typedef struct packed {
        logic signed [DATA_W-1:0] data;
        logic                     last;
    } mrc_entry_t;

endpackage

`default_nettype wire

### sv/mrc_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module mrc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

### sv/mrc_front.sv
// front end: config, frame counters, bank select, address generation, clearing pass
`default_nettype none

module mrc_front #(
    parameter int MAX_SIDE = mrc_pkg::MAX_SIDE_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  push,
    output logic                                       full,
    input  wire logic signed [mrc_pkg::DATA_W-1:0]     element_in,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [mrc_pkg::SIDE_W-1:0]            side_length,
    input  wire logic [mrc_pkg::QCNT_W-1:0]            q_count,
    output logic                                       ram_we,
    output logic [$clog2(2*MAX_SIDE*MAX_SIDE)-1:0]     ram_waddr,
    output logic [mrc_pkg::DATA_W-1:0]                 ram_wdata,
    output logic                                       ram_re,
    output logic [$clog2(2*MAX_SIDE*MAX_SIDE)-1:0]     ram_raddr,
    output mrc_pkg::mrc_tag_t                          tag
);

    import mrc_pkg::*;

    localparam int BANK_WORDS = MAX_SIDE * MAX_SIDE;
    localparam int DEPTH      = 2 * BANK_WORDS;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(MAX_SIDE);
    localparam int EW         = (CNT_W + 1 > SIDE_W) ? CNT_W + 1 : SIDE_W;

    logic [SIDE_W-1:0] side_reg;
    logic              bank_reg,  bank_next;
    logic [CNT_W-1:0]  row_reg,   row_next;
    logic [CNT_W-1:0]  col_reg,   col_next;
    logic              clr_busy_reg;
    logic [ADDR_W-1:0] clr_addr_reg;
    mrc_tag_t          tag_reg,   tag_next;

    logic [EW-1:0]     side_ext;
    logic [EW-1:0]     eff;
    logic [CNT_W-1:0]  nm1;
    logic              accept;
    logic              at_col_end;
    logic              at_row_end;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;

    // 0 acts as 1, anything above the largest side acts as the largest side
    always_comb
    begin
        side_ext = EW'(side_reg);
        if (side_ext == '0)
        begin
            eff = EW'(1);
        end
        else if (side_ext > EW'(MAX_SIDE))
        begin
            eff = EW'(MAX_SIDE);
        end
        else
        begin
            eff = side_ext;
        end
        nm1 = CNT_W'(eff - EW'(1));
    end

    // room for the request in flight plus this one
    assign full      = clr_busy_reg
                     || ((QCNT_W+1)'(q_count) + (QCNT_W+1)'(tag_reg.valid)
                         >= (QCNT_W+1)'(QDEPTH));
    assign accept    = push && !full;
    assign cfg_ready = 1'b1;

    assign at_col_end = (col_reg == nm1);
    assign at_row_end = (row_reg == nm1);

    // write into the current bank, read rotated source from the other
    assign wr_addr = ADDR_W'(bank_reg) * ADDR_W'(BANK_WORDS)
                   + ADDR_W'(row_reg) * ADDR_W'(MAX_SIDE)
                   + ADDR_W'(col_reg);
    assign rd_addr = ADDR_W'(!bank_reg) * ADDR_W'(BANK_WORDS)
                   + ADDR_W'(nm1 - col_reg) * ADDR_W'(MAX_SIDE)
                   + ADDR_W'(row_reg);

    assign ram_we    = clr_busy_reg || accept;
    assign ram_waddr = clr_busy_reg ? clr_addr_reg : wr_addr;
    assign ram_wdata = clr_busy_reg ? '0 : DATA_W'(element_in);
    assign ram_re    = accept;
    assign ram_raddr = rd_addr;
    assign tag       = tag_reg;

    always_comb
    begin
        bank_next = bank_reg;
        row_next  = row_reg;
        col_next  = col_reg;
        tag_next.valid = accept;
        tag_next.last  = at_col_end && at_row_end;
        if (accept)
        begin
            if (at_col_end)
            begin
                col_next = '0;
                if (at_row_end)
                begin
                    row_next  = '0;
                    bank_next = !bank_reg;
                end
                else
                begin
                    row_next = row_reg + CNT_W'(1);
                end
            end
            else
            begin
                col_next = col_reg + CNT_W'(1);
            end
        end
        // new side length restarts the frame
        if (cfg_valid && cfg_ready)
        begin
            row_next = '0;
            col_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg     <= SIDE_RESET;
            bank_reg     <= 1'b0;
            row_reg      <= '0;
            col_reg      <= '0;
            tag_reg      <= '0;
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            bank_reg <= bank_next;
            row_reg  <= row_next;
            col_reg  <= col_next;
            tag_reg  <= tag_next;
            if (cfg_valid && cfg_ready)
            begin
                side_reg <= side_length;
            end
            if (clr_busy_reg)
            begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == ADDR_W'(DEPTH - 1))
                begin
                    clr_busy_reg <= 1'b0;
                end
            end
        end
    end

endmodule

`default_nettype wire

### sv/mrc_queue.sv
// back end: small result queue between the ram read and the output side
`default_nettype none

module mrc_queue (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         wr_en,
    input  wire mrc_pkg::mrc_entry_t          wr_entry,
    input  wire logic                         pop,
    output logic                              empty,
    output mrc_pkg::mrc_entry_t               head,
    output logic [mrc_pkg::QCNT_W-1:0]        count
);

    import mrc_pkg::*;

    mrc_entry_t        slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              rd_en;

    assign empty = (count_reg == '0);
    assign rd_en = pop && !empty;
    assign head  = slot_reg[rd_ptr_reg];
    assign count = count_reg;

    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= wr_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

### sv/matrix_rotate_clockwise.sv
// top level of the streaming clockwise matrix rotator
// a request's result passes the ram read data register and then a queue slot before it can be popped
// throughput: one request per cycle while full is low, set by the single write and read port of the bank ram
// each accepted request yields one result from the previous frame, rotated
// reset: asynchronous, active low; after it a clearing pass zeroes all 2*MAX_SIDE*MAX_SIDE
// words of both banks (512 at the default side of 16) with full held high
`default_nettype none

module matrix_rotate_clockwise #(
    parameter int MAX_SIDE = mrc_pkg::MAX_SIDE_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // request side
    input  wire logic                              push,
    output logic                                   full,
    input  wire logic signed [mrc_pkg::DATA_W-1:0] element_in,
    // result side
    output logic                                   empty,
    input  wire logic                              pop,
    output logic signed [mrc_pkg::DATA_W-1:0]      element_out,
    output logic                                   frame_last,
    // side length register write
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [mrc_pkg::SIDE_W-1:0]        side_length
);

    import mrc_pkg::*;

    localparam int DEPTH  = 2 * MAX_SIDE * MAX_SIDE;
    localparam int ADDR_W = $clog2(DEPTH);

    // bank ram port signals from the front end
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    // read in flight, and queue status back to the front for flow control
    mrc_tag_t          tag;
    logic [QCNT_W-1:0] q_count;
    mrc_entry_t        q_in;
    mrc_entry_t        q_head;

    // front: takes requests and config, walks the frame, drives both ram ports,
    // holds off requests while the banks are being cleared or the queue is short
    mrc_front #(
        .MAX_SIDE (MAX_SIDE)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .element_in  (element_in),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .side_length (side_length),
        .q_count     (q_count),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_re      (ram_re),
        .ram_raddr   (ram_raddr),
        .tag         (tag)
    );

    // both banks live in one ram: bank select is the top part of the address;
    // the read always targets the bank not being written, so the two never collide
    mrc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // read data is valid for one cycle only, so it goes straight into the queue;
    // the front only issues a read when the queue is sure to have room
    assign q_in.data = $signed(ram_rdata);
    assign q_in.last = tag.last;

    // back: result queue that decouples the output side from the ram pipe
    mrc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (tag.valid),
        .wr_entry (q_in),
        .pop      (pop),
        .empty    (empty),
        .head     (q_head),
        .count    (q_count)
    );

    assign element_out = q_head.data;
    assign frame_last  = q_head.last;

    // an accepted request always has its ram read in flight on the next cycle
    a_accept_reads : assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full) |=> tag.valid)
        else $error("accepted request without a read in flight");

    // no read lands in the queue unless it was requested
    a_no_spurious_read : assert property (@(posedge clk) disable iff (!rst_n)
        !(push && !full) |=> !tag.valid)
        else $error("read in flight without an accepted request");

    // flow control keeps a free slot for every read in flight
    a_queue_room : assert property (@(posedge clk) disable iff (!rst_n)
        tag.valid |-> (q_count < QCNT_W'(QDEPTH)))
        else $error("result queue overflow");

endmodule

`default_nettype wire
